// File: rtl/core/jsu_pkg.sv
`default_nettype none
package jsu_pkg;

  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 4;
  localparam int MODE_W   = 4;
  localparam int MAX_OUT  = 4;
  localparam int CNT_W    = 3;
  localparam int CP_W     = 21;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_BYTE          = 4'd0;
  localparam logic [STATUS_W-1:0] ST_DONE          = 4'd1;
  localparam logic [STATUS_W-1:0] ST_END_IDLE      = 4'd2;
  localparam logic [STATUS_W-1:0] ST_NO_QUOTE      = 4'd3;
  localparam logic [STATUS_W-1:0] ST_UNTERM_STR    = 4'd4;
  localparam logic [STATUS_W-1:0] ST_UNTERM_ESC    = 4'd5;
  localparam logic [STATUS_W-1:0] ST_BAD_ESC       = 4'd6;
  localparam logic [STATUS_W-1:0] ST_INCOMPLETE_U  = 4'd7;
  localparam logic [STATUS_W-1:0] ST_BAD_HEX       = 4'd8;

  // decoder modes
  localparam logic [MODE_W-1:0] M_IDLE   = 4'd0;
  localparam logic [MODE_W-1:0] M_BODY   = 4'd1;
  localparam logic [MODE_W-1:0] M_ESC    = 4'd2;
  localparam logic [MODE_W-1:0] M_HEX1   = 4'd3;
  localparam logic [MODE_W-1:0] M_HIGH   = 4'd4;
  localparam logic [MODE_W-1:0] M_HIGHBS = 4'd5;
  localparam logic [MODE_W-1:0] M_HEX2   = 4'd6;

  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_U     = 8'h75;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic [STATUS_W-1:0] status;
    logic                last;
  } out_beat_t;

  typedef struct packed {
    logic [MAX_OUT-1:0][BYTE_W-1:0] b;
    logic [CNT_W-1:0]               cnt;
  } enc_t;

endpackage
`default_nettype wire

// File: rtl/core/jsu_in_if.sv
`default_nettype none
interface jsu_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [jsu_pkg::BYTE_W-1:0] in_byte;

  modport source(output valid, output action, output in_byte, input ready);
  modport sink(input valid, input action, input in_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/core/jsu_out_if.sv
`default_nettype none
interface jsu_out_if;
  logic                        valid;
  logic                        ready;
  logic [jsu_pkg::BYTE_W-1:0]   out_byte;
  logic [jsu_pkg::STATUS_W-1:0] status;
  logic                        last;

  modport source(output valid, output out_byte, output status, output last, input ready);
  modport sink(input valid, input out_byte, input status, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/json_string_unescape_utf8.sv
// output: results of a byte are registered and appear in the cycle after its beat is accepted
// throughput: one input byte per cycle while each byte yields at most one result and the
//   receiver is ready; a byte that yields more results (up to four) holds the input until
//   the four-entry result buffer, draining one beat per cycle while the receiver is ready,
//   is down to its last beat; reset: synchronous active-low rst_n empties the buffer and
//   returns the decoder to waiting for an opening quote
`default_nettype none
module json_string_unescape_utf8 (
  input  wire logic  clk,
  input  wire logic  rst_n,
  jsu_in_if.sink     in_chan,
  jsu_out_if.source  out_chan
);

  localparam int MAX_OUT = jsu_pkg::MAX_OUT;

  logic [jsu_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [2:0]                 seen_r, seen_nxt;
  logic [15:0]                hv_r, hv_nxt;
  logic [15:0]                hh_r, hh_nxt;
  logic                       bad_r, bad_nxt;

  jsu_pkg::out_beat_t         buf_r [MAX_OUT];
  jsu_pkg::out_beat_t         buf_nxt [MAX_OUT];
  logic [jsu_pkg::CNT_W-1:0]  count_r, count_nxt;

  jsu_pkg::out_beat_t         res [MAX_OUT];
  logic [jsu_pkg::CNT_W-1:0]  res_n;

  logic       accept, pop;
  logic [7:0] c;

  function automatic jsu_pkg::enc_t encode(input logic [jsu_pkg::CP_W-1:0] cp);
    jsu_pkg::enc_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.b[0] = cp[7:0];
      e.cnt  = 3'd1;
    end else if (cp < 21'h800) begin
      e.b[0] = 8'hC0 | {3'b000, cp[10:6]};
      e.b[1] = 8'h80 | {2'b00, cp[5:0]};
      e.cnt  = 3'd2;
    end else if (cp < 21'h10000) begin
      e.b[0] = 8'hE0 | {4'h0, cp[15:12]};
      e.b[1] = 8'h80 | {2'b00, cp[11:6]};
      e.b[2] = 8'h80 | {2'b00, cp[5:0]};
      e.cnt  = 3'd3;
    end else begin
      e.b[0] = 8'hF0 | {5'b00000, cp[20:18]};
      e.b[1] = 8'h80 | {2'b00, cp[17:12]};
      e.b[2] = 8'h80 | {2'b00, cp[11:6]};
      e.b[3] = 8'h80 | {2'b00, cp[5:0]};
      e.cnt  = 3'd4;
    end
    return e;
  endfunction

  function automatic jsu_pkg::out_beat_t data_beat(input logic [7:0] b);
    jsu_pkg::out_beat_t r;
    r.out_byte = b;
    r.status   = jsu_pkg::ST_BYTE;
    r.last     = 1'b0;
    return r;
  endfunction

  function automatic jsu_pkg::out_beat_t end_beat(input logic [jsu_pkg::STATUS_W-1:0] st);
    jsu_pkg::out_beat_t r;
    r.out_byte = '0;
    r.status   = st;
    r.last     = 1'b1;
    return r;
  endfunction

  // simple escape lookup
  logic       esc_ok;
  logic [7:0] esc_val;
  always_comb begin
    esc_ok  = 1'b1;
    esc_val = c;
    unique case (c) inside
      8'h22, 8'h5C, 8'h2F: esc_val = c;
      8'h62: esc_val = 8'h08;
      8'h66: esc_val = 8'h0C;
      8'h6E: esc_val = 8'h0A;
      8'h72: esc_val = 8'h0D;
      8'h74: esc_val = 8'h09;
      default: esc_ok = 1'b0;
    endcase
  end

  // hex digit decode
  logic       is_hex;
  logic [3:0] digit;
  always_comb begin
    is_hex = 1'b1;
    digit  = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      digit = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      digit = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      digit = 4'(c - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  logic [15:0]              hv_shift;
  logic [2:0]               seen_inc;
  logic                     bad_acc;
  logic [jsu_pkg::CP_W-1:0] cp_pair;
  jsu_pkg::enc_t            enc_hi, enc_hex1, enc_hex2;

  assign hv_shift = {hv_r[11:0], digit};
  assign seen_inc = seen_r + 3'd1;
  assign bad_acc  = bad_r | ~is_hex;
  assign cp_pair  = 21'h10000 + {1'b0, hh_r[9:0], hv_shift[9:0]};
  assign enc_hi   = encode({5'b00000, hh_r});
  assign enc_hex1 = encode({5'b00000, hv_shift});
  assign enc_hex2 = encode((hv_shift >= 16'hDC00 && hv_shift <= 16'hDFFF) ?
                           cp_pair : {5'b00000, hh_r});

  assign c = in_chan.in_byte;

  always_comb begin
    mode_nxt = mode_r;
    seen_nxt = seen_r;
    hv_nxt   = hv_r;
    hh_nxt   = hh_r;
    bad_nxt  = bad_r;
    res_n    = '0;
    for (int i = 0; i < MAX_OUT; i++) begin
      res[i] = data_beat(8'h00);
    end

    if (in_chan.action) begin
      mode_nxt = jsu_pkg::M_IDLE;
      seen_nxt = '0;
      hv_nxt   = '0;
      hh_nxt   = '0;
      bad_nxt  = 1'b0;
      unique case (mode_r) inside
        jsu_pkg::M_IDLE: begin
          res[0] = end_beat(jsu_pkg::ST_END_IDLE);
          res_n  = 3'd1;
        end
        jsu_pkg::M_BODY: begin
          res[0] = end_beat(jsu_pkg::ST_UNTERM_STR);
          res_n  = 3'd1;
        end
        jsu_pkg::M_ESC: begin
          res[0] = end_beat(jsu_pkg::ST_UNTERM_ESC);
          res_n  = 3'd1;
        end
        jsu_pkg::M_HIGH, jsu_pkg::M_HIGHBS: begin
          // pending surrogate always encodes as three bytes
          for (int i = 0; i < 3; i++) begin
            res[i] = data_beat(enc_hi.b[i]);
          end
          res[3] = end_beat((mode_r == jsu_pkg::M_HIGH) ?
                            jsu_pkg::ST_UNTERM_STR : jsu_pkg::ST_UNTERM_ESC);
          res_n  = 3'd4;
        end
        default: begin
          res[0] = end_beat(jsu_pkg::ST_INCOMPLETE_U);
          res_n  = 3'd1;
        end
      endcase
    end else begin
      unique case (mode_r) inside
        jsu_pkg::M_IDLE: begin
          if (c == jsu_pkg::CH_QUOTE) begin
            mode_nxt = jsu_pkg::M_BODY;
          end else begin
            res[0] = end_beat(jsu_pkg::ST_NO_QUOTE);
            res_n  = 3'd1;
          end
        end
        jsu_pkg::M_BODY, jsu_pkg::M_HIGH: begin
          if (mode_r == jsu_pkg::M_HIGH && c == jsu_pkg::CH_BSL) begin
            mode_nxt = jsu_pkg::M_HIGHBS;
          end else begin
            if (mode_r == jsu_pkg::M_HIGH) begin
              for (int i = 0; i < 3; i++) begin
                res[i] = data_beat(enc_hi.b[i]);
              end
            end
            mode_nxt = jsu_pkg::M_BODY;
            // body byte lands after any flushed surrogate bytes
            if (c == jsu_pkg::CH_QUOTE) begin
              res[(mode_r == jsu_pkg::M_HIGH) ? 3 : 0] = end_beat(jsu_pkg::ST_DONE);
              res_n    = (mode_r == jsu_pkg::M_HIGH) ? 3'd4 : 3'd1;
              mode_nxt = jsu_pkg::M_IDLE;
              seen_nxt = '0;
              hv_nxt   = '0;
              hh_nxt   = '0;
              bad_nxt  = 1'b0;
            end else if (c == jsu_pkg::CH_BSL) begin
              res_n    = (mode_r == jsu_pkg::M_HIGH) ? 3'd3 : 3'd0;
              mode_nxt = jsu_pkg::M_ESC;
            end else begin
              res[(mode_r == jsu_pkg::M_HIGH) ? 3 : 0] = data_beat(c);
              res_n = (mode_r == jsu_pkg::M_HIGH) ? 3'd4 : 3'd1;
            end
          end
        end
        jsu_pkg::M_ESC, jsu_pkg::M_HIGHBS: begin
          if (c == jsu_pkg::CH_U) begin
            mode_nxt = (mode_r == jsu_pkg::M_ESC) ? jsu_pkg::M_HEX1 : jsu_pkg::M_HEX2;
            seen_nxt = '0;
            hv_nxt   = '0;
            bad_nxt  = 1'b0;
          end else begin
            if (mode_r == jsu_pkg::M_HIGHBS) begin
              for (int i = 0; i < 3; i++) begin
                res[i] = data_beat(enc_hi.b[i]);
              end
            end
            res_n = (mode_r == jsu_pkg::M_HIGHBS) ? 3'd4 : 3'd1;
            if (esc_ok) begin
              res[(mode_r == jsu_pkg::M_HIGHBS) ? 3 : 0] = data_beat(esc_val);
              mode_nxt = jsu_pkg::M_BODY;
            end else begin
              res[(mode_r == jsu_pkg::M_HIGHBS) ? 3 : 0] = end_beat(jsu_pkg::ST_BAD_ESC);
              mode_nxt = jsu_pkg::M_IDLE;
              seen_nxt = '0;
              hv_nxt   = '0;
              hh_nxt   = '0;
              bad_nxt  = 1'b0;
            end
          end
        end
        jsu_pkg::M_HEX1, jsu_pkg::M_HEX2: begin
          hv_nxt   = hv_shift;
          seen_nxt = seen_inc;
          bad_nxt  = bad_acc;
          if (seen_inc >= 3'd4) begin
            if (bad_acc) begin
              res[0]   = end_beat(jsu_pkg::ST_BAD_HEX);
              res_n    = 3'd1;
              mode_nxt = jsu_pkg::M_IDLE;
              seen_nxt = '0;
              hv_nxt   = '0;
              hh_nxt   = '0;
              bad_nxt  = 1'b0;
            end else if (mode_r == jsu_pkg::M_HEX1 &&
                         hv_shift >= 16'hD800 && hv_shift <= 16'hDBFF) begin
              hh_nxt   = hv_shift;
              mode_nxt = jsu_pkg::M_HIGH;
            end else begin
              for (int i = 0; i < MAX_OUT; i++) begin
                res[i] = data_beat((mode_r == jsu_pkg::M_HEX1) ?
                                   enc_hex1.b[i] : enc_hex2.b[i]);
              end
              res_n    = (mode_r == jsu_pkg::M_HEX1) ? enc_hex1.cnt : enc_hex2.cnt;
              mode_nxt = jsu_pkg::M_BODY;
            end
          end
        end
        default: begin
          mode_nxt = jsu_pkg::M_IDLE;
          seen_nxt = '0;
          hv_nxt   = '0;
          hh_nxt   = '0;
          bad_nxt  = 1'b0;
        end
      endcase
    end
  end

  // result buffer: head beat sits in entry zero
  assign pop            = out_chan.valid & out_chan.ready;
  assign in_chan.ready  = (count_r == 3'd0) || (count_r == 3'd1 && out_chan.ready);
  assign accept         = in_chan.valid & in_chan.ready;
  assign out_chan.valid = (count_r != 3'd0);
  assign out_chan.out_byte = buf_r[0].out_byte;
  assign out_chan.status   = buf_r[0].status;
  assign out_chan.last     = buf_r[0].last;

  always_comb begin
    count_nxt = count_r;
    for (int i = 0; i < MAX_OUT; i++) begin
      buf_nxt[i] = buf_r[i];
    end
    if (accept) begin
      for (int i = 0; i < MAX_OUT; i++) begin
        buf_nxt[i] = res[i];
      end
      count_nxt = res_n;
    end else if (pop) begin
      for (int i = 0; i < MAX_OUT - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
      count_nxt = count_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_OUT; i++) begin
      buf_r[i] <= buf_nxt[i];
    end
    if (!rst_n) begin
      count_r <= '0;
      mode_r  <= jsu_pkg::M_IDLE;
      seen_r  <= '0;
      hv_r    <= '0;
      hh_r    <= '0;
      bad_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        mode_r <= mode_nxt;
        seen_r <= seen_nxt;
        hv_r   <= hv_nxt;
        hh_r   <= hh_nxt;
        bad_r  <= bad_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// File: sim/json_string_unescape_utf8_tb.sv
`default_nettype none
module json_string_unescape_utf8_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jsu_pkg::*;

  localparam logic [15:0] HIGH_MIN = 16'hD800;
  localparam logic [15:0] HIGH_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_MAX  = 16'hDFFF;
  localparam int SUPP_BASE      = 'h10000;
  localparam int DIRECTED_BEATS = 24;
  localparam int RANDOM_BEATS   = 406;
  localparam int HOLD_AT        = DIRECTED_BEATS + 300;
  localparam int HOLD_CYCLES    = 64;
  localparam int MAX_SHOWN      = 10;

  class unescape_scoreboard;
    out_beat_t         due_q[$];
    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0]  digit_cnt;
    logic [15:0]       hex_acc;
    logic [15:0]       high_sur;
    bit                bad_digit;
    int                mismatches;
    int                results_checked;
    int                status_count[9];

    function new();
      go_idle();
    endfunction

    function void go_idle();
      mode      = M_IDLE;
      digit_cnt = '0;
      hex_acc   = '0;
      high_sur  = '0;
      bad_digit = 1'b0;
    endfunction

    function void put(logic [7:0] b, logic [STATUS_W-1:0] st, logic lst);
      out_beat_t r;
      r.out_byte = b;
      r.status   = st;
      r.last     = lst;
      due_q.insert(due_q.size(), r);
      status_count[st]++;
    endfunction

    function void fail(logic [STATUS_W-1:0] st);
      put(8'h00, st, 1'b1);
      go_idle();
    endfunction

    function void start_hex(logic [MODE_W-1:0] next_mode);
      mode      = next_mode;
      digit_cnt = '0;
      hex_acc   = '0;
      bad_digit = 1'b0;
    endfunction

    function void encode(int cp);
      if (cp < 'h80) begin
        put(cp[7:0], ST_BYTE, 1'b0);
      end else if (cp < 'h800) begin
        put({3'b110, cp[10:6]}, ST_BYTE, 1'b0);
        put({2'b10, cp[5:0]}, ST_BYTE, 1'b0);
      end else if (cp < 'h10000) begin
        put({4'b1110, cp[15:12]}, ST_BYTE, 1'b0);
        put({2'b10, cp[11:6]}, ST_BYTE, 1'b0);
        put({2'b10, cp[5:0]}, ST_BYTE, 1'b0);
      end else begin
        put({5'b11110, cp[20:18]}, ST_BYTE, 1'b0);
        put({2'b10, cp[17:12]}, ST_BYTE, 1'b0);
        put({2'b10, cp[11:6]}, ST_BYTE, 1'b0);
        put({2'b10, cp[5:0]}, ST_BYTE, 1'b0);
      end
    endfunction

    function void body_char(logic [7:0] c);
      if (c == CH_QUOTE) begin
        put(8'h00, ST_DONE, 1'b1);
        go_idle();
      end else if (c == CH_BSL) begin
        mode = M_ESC;
      end else begin
        put(c, ST_BYTE, 1'b0);
      end
    endfunction

    function void esc_char(logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      case (c)
        CH_QUOTE: v = CH_QUOTE;
        CH_BSL:   v = CH_BSL;
        "/":      v = "/";
        "b":      v = 8'h08;
        "f":      v = 8'h0C;
        "n":      v = 8'h0A;
        "r":      v = 8'h0D;
        "t":      v = 8'h09;
        CH_U: begin
          start_hex(M_HEX1);
          return;
        end
        default: begin
          fail(ST_BAD_ESC);
          return;
        end
      endcase
      put(v, ST_BYTE, 1'b0);
      mode = M_BODY;
    endfunction

    function void hex_char(logic [7:0] c);
      logic [3:0] d;
      int         cp;
      d = 4'h0;
      if (c >= "0" && c <= "9") d = 4'(c - "0");
      else if (c >= "a" && c <= "f") d = 4'(c - "a" + 10);
      else if (c >= "A" && c <= "F") d = 4'(c - "A" + 10);
      else bad_digit = 1'b1;
      hex_acc   = {hex_acc[11:0], d};
      digit_cnt = digit_cnt + 1'b1;
      if (digit_cnt < 4) return;
      if (bad_digit) begin
        fail(ST_BAD_HEX);
        return;
      end
      if (mode == M_HEX1) begin
        if (hex_acc >= HIGH_MIN && hex_acc <= HIGH_MAX) begin
          high_sur = hex_acc;
          mode     = M_HIGH;
          return;
        end
        cp = int'(hex_acc);
      end else if (hex_acc >= LOW_MIN && hex_acc <= LOW_MAX) begin
        cp = SUPP_BASE + ((int'(high_sur) - int'(HIGH_MIN)) << 10)
             + (int'(hex_acc) - int'(LOW_MIN));
      end else begin
        // second value is not a low half: it is dropped
        cp = int'(high_sur);
      end
      encode(cp);
      mode = M_BODY;
    endfunction

    function void note_input(logic act, logic [7:0] c);
      if (act) begin
        case (mode)
          M_IDLE: fail(ST_END_IDLE);
          M_BODY: fail(ST_UNTERM_STR);
          M_ESC:  fail(ST_UNTERM_ESC);
          M_HIGH: begin
            encode(int'(high_sur));
            fail(ST_UNTERM_STR);
          end
          M_HIGHBS: begin
            encode(int'(high_sur));
            fail(ST_UNTERM_ESC);
          end
          default: fail(ST_INCOMPLETE_U);
        endcase
        return;
      end
      case (mode) inside
        M_IDLE: begin
          if (c == CH_QUOTE) mode = M_BODY;
          else fail(ST_NO_QUOTE);
        end
        M_BODY: body_char(c);
        M_ESC:  esc_char(c);
        M_HIGH: begin
          if (c == CH_BSL) begin
            mode = M_HIGHBS;
          end else begin
            encode(int'(high_sur));
            mode = M_BODY;
            body_char(c);
          end
        end
        M_HIGHBS: begin
          if (c == CH_U) begin
            start_hex(M_HEX2);
          end else begin
            encode(int'(high_sur));
            mode = M_BODY;
            esc_char(c);
          end
        end
        M_HEX1, M_HEX2: hex_char(c);
        default: go_idle();
      endcase
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      results_checked++;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result: byte %02h status %0d last %0d",
                   got.out_byte, got.status, got.last);
        return;
      end
      want = due_q.pop_front();
      if (got.out_byte !== want.out_byte || got.status !== want.status ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display({"result %0d: want byte %02h status %0d last %0d,",
                    " got byte %02h status %0d last %0d"},
                   results_checked, want.out_byte, want.status, want.last,
                   got.out_byte, got.status, got.last);
      end
    endfunction

    function void close_out();
      if (due_q.size() != 0) begin
        mismatches += due_q.size();
        $display("%0d expected results never arrived", due_q.size());
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  jsu_in_if  in_chan();
  jsu_out_if out_chan();

  json_string_unescape_utf8 dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  unescape_scoreboard book = new();

  int beats_sent  = 0;
  int beats_in    = 0;
  int tx_idle_pct = 28;
  int rx_idle_pct = 85;
  int hold_left   = 0;
  bit hold_done   = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin : watch
    out_beat_t got;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        book.note_input(in_chan.action, in_chan.in_byte);
        beats_in++;
      end
      if (out_chan.valid && out_chan.ready) begin
        got.out_byte = out_chan.out_byte;
        got.status   = out_chan.status;
        got.last     = out_chan.last;
        book.check_result(got);
      end
    end
  end

  // receiver: random stalls plus one long hold-off once enough beats went in
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && beats_in >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("json_string_unescape_utf8_tb NOT OK");
    $finish;
  end

  function automatic bit is_hex(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit is_simple_esc(logic [7:0] c);
    return c == CH_QUOTE || c == CH_BSL || c == "/" || c == "b" || c == "f" ||
           c == "n" || c == "r" || c == "t";
  endfunction

  function automatic logic [7:0] hex_ascii(logic [3:0] n);
    if (n < 10) return 8'("0" + n);
    return 8'(($urandom_range(1) ? "A" : "a") + n - 10);
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CH_QUOTE || c == CH_BSL);
    return c;
  endfunction

  function automatic logic [7:0] simple_esc();
    case ($urandom_range(7))
      0: return CH_QUOTE;
      1: return CH_BSL;
      2: return "/";
      3: return "b";
      4: return "f";
      5: return "n";
      6: return "r";
      default: return "t";
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic push_beat(logic act, logic [7:0] c);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.action  <= act;
    in_chan.in_byte <= c;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic push_byte(logic [7:0] c);
    push_beat(1'b0, c);
  endtask

  task automatic push_end();
    push_beat(1'b1, 8'($urandom_range(255)));
  endtask

  // \u escape; bad_pos picks one digit to replace by a non-hex byte, -1 for none
  task automatic push_u(logic [15:0] v, int bad_pos);
    logic [7:0] c;
    push_byte(CH_BSL);
    push_byte(CH_U);
    for (int i = 0; i < 4; i++) begin
      if (i == bad_pos) begin
        do c = 8'($urandom_range(255)); while (is_hex(c));
      end else begin
        c = hex_ascii(v[15 - 4*i -: 4]);
      end
      push_byte(c);
    end
  endtask

  task automatic push_token(output bit broke);
    int          r;
    logic [15:0] v;
    logic [7:0]  c;
    broke = 1'b0;
    r = $urandom_range(99);
    if (r < 35) begin
      push_byte(plain_char());
    end else if (r < 50) begin
      push_byte(CH_BSL);
      push_byte(simple_esc());
    end else if (r < 70) begin
      case ($urandom_range(5))
        0: v = 16'($urandom_range('h7F));
        1: v = 16'($urandom_range('h80, 'h7FF));
        2: v = 16'($urandom_range('h800, 'hD7FF));
        3: v = 16'($urandom_range('hE000, 'hFFFF));
        4: v = 16'($urandom_range(LOW_MIN, LOW_MAX));
        default: begin
          case ($urandom_range(3))
            0: v = 16'h0000;
            1: v = 16'h07FF;
            2: v = 16'h0800;
            default: v = 16'hFFFF;
          endcase
        end
      endcase
      push_u(v, -1);
    end else if (r < 88) begin
      push_u(16'($urandom_range(HIGH_MIN, HIGH_MAX)), -1);
      r = $urandom_range(99);
      if (r < 50) begin
        push_u(16'($urandom_range(LOW_MIN, LOW_MAX)), -1);
      end else if (r < 65) begin
        do v = 16'($urandom()); while (v >= LOW_MIN && v <= LOW_MAX);
        push_u(v, -1);
      end else if (r < 75) begin
        push_byte(plain_char());
      end else if (r < 85) begin
        push_byte(CH_BSL);
        push_byte(simple_esc());
      end
    end else if (r < 94) begin
      push_u(16'($urandom()), $urandom_range(3));
      broke = 1'b1;
    end else begin
      do c = 8'($urandom_range(255)); while (is_simple_esc(c) || c == CH_U);
      push_byte(CH_BSL);
      push_byte(c);
      broke = 1'b1;
    end
  endtask

  task automatic push_string();
    int ntok;
    int r;
    bit broke;
    broke = 1'b0;
    // stray bytes and end marks between strings
    if ($urandom_range(99) < 8) begin
      if ($urandom_range(1)) push_end();
      else push_byte(plain_char());
    end
    ntok = ($urandom_range(9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 5);
    push_byte(CH_QUOTE);
    for (int i = 0; i < ntok && !broke; i++) push_token(broke);
    if (broke) return;
    r = $urandom_range(99);
    if (r < 74) begin
      push_byte(CH_QUOTE);
    end else if (r < 86) begin
      push_end();
    end else if (r < 91) begin
      push_byte(CH_BSL);
      push_end();
    end else if (r < 95) begin
      push_byte(CH_BSL);
      push_byte(CH_U);
      repeat ($urandom_range(3)) push_byte(hex_ascii(4'($urandom_range(15))));
      push_end();
    end else if (r < 98) begin
      push_u(16'($urandom_range(HIGH_MIN, HIGH_MAX)), -1);
      push_byte(CH_BSL);
      push_end();
    end
    // otherwise the string is left open; the next string's opening quote closes it unless a stray end mark comes first
  endtask

  task automatic run_strings(int stop_at);
    while (beats_sent < stop_at) push_string();
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    rst_n           = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.action  = 1'b0;
    in_chan.in_byte = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_end();
    push_byte(8'hFF);
    // highest code point as a surrogate pair
    push_byte(CH_QUOTE);
    push_u(HIGH_MAX, -1);
    push_u(LOW_MAX, -1);
    push_byte(CH_QUOTE);
    // end with a high half still pending
    push_byte(CH_QUOTE);
    push_u(HIGH_MIN, -1);
    push_end();

    run_strings(DIRECTED_BEATS + 140);
    settle();
    tx_idle_pct = 85;
    rx_idle_pct = 28;
    run_strings(DIRECTED_BEATS + 280);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_strings(DIRECTED_BEATS + RANDOM_BEATS);
    settle();
    book.close_out();

    $display("covered %0d input beats and %0d results: %0d strings closed, %0d unterminated",
             beats_in, book.results_checked, book.status_count[ST_DONE],
             book.status_count[ST_UNTERM_STR] + book.status_count[ST_UNTERM_ESC]);
    $display({"bad escapes %0d, bad hex %0d, short unicode %0d, stray bytes %0d,",
              " long stall %0d cycles"},
             book.status_count[ST_BAD_ESC], book.status_count[ST_BAD_HEX],
             book.status_count[ST_INCOMPLETE_U], book.status_count[ST_NO_QUOTE], HOLD_CYCLES);
    if (book.mismatches == 0) begin
      $display("json_string_unescape_utf8_tb OK");
    end else begin
      $display("%0d mismatches", book.mismatches);
      $display("json_string_unescape_utf8_tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
